// ===== design/si64alu_pkg.sv =====
// Shared constants for the signed four-operation ALU: port widths, command
// codes and status codes. Depends on nothing; imported by the top level.
package si64alu_pkg;

    // Fixed port widths
    localparam int XLEN  = 64;
    localparam int CMD_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

    // Status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

endpackage

// ===== design/si64alu_mul.sv =====
// Two-stage multiplier that keeps the low W bits of the product, built from
// half-width partial products. Standalone; instantiated by the top level.
module si64alu_mul #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] prod
);

    localparam int LO_W = (W + 1) / 2;
    localparam int HI_W = W - LO_W;

    logic [2*LO_W-1:0] ll_next;
    logic [W-1:0]      lh_full;
    logic [W-1:0]      hl_full;
    logic [W-1:0]      ll_reg;
    logic [HI_W-1:0]   cross_reg;
    logic [HI_W-1:0]   cross_next;
    logic [W-1:0]      prod_next;
    logic [W-1:0]      prod_reg;

    // Form the partial products; cross terms only matter below bit W
    assign ll_next    = {{LO_W{1'b0}}, a[LO_W-1:0]} * {{LO_W{1'b0}}, b[LO_W-1:0]};
    assign lh_full    = {{HI_W{1'b0}}, a[LO_W-1:0]} * {{LO_W{1'b0}}, b[W-1:LO_W]};
    assign hl_full    = {{LO_W{1'b0}}, a[W-1:LO_W]} * {{HI_W{1'b0}}, b[LO_W-1:0]};
    assign cross_next = lh_full[HI_W-1:0] + hl_full[HI_W-1:0];

    always_ff @(posedge clk)
    begin
        ll_reg    <= ll_next[W-1:0];
        cross_reg <= cross_next;
    end

    // Combine the low product with the shifted cross sum
    assign prod_next = ll_reg + {cross_reg, {LO_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== design/si64alu_div.sv =====
// Unsigned restoring divider, one quotient bit per register stage, W stages.
// Standalone; instantiated by the top level, which handles signs and zero.
module si64alu_div #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient
);

    // Partial remainder and divisor are not needed after the last stage
    logic [W-1:0] rem_reg [W-1];
    logic [W-1:0] dvs_reg [W-1];
    logic [W-1:0] dq_reg  [W];

    for (genvar i = 0; i < W; i++)
    begin : g_stage
        logic [W-1:0] rem_in;
        logic [W-1:0] dq_in;
        logic [W-1:0] dvs_in;
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic         q_bit;
        logic [W-1:0] dq_next;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign dq_in  = dividend;
            assign dvs_in = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign dq_in  = dq_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
        end

        // Shift in the next dividend bit and try to subtract the divisor
        assign trial    = {rem_in, dq_in[W-1]};
        assign diff     = trial - {1'b0, dvs_in};
        assign q_bit    = ~diff[W];
        assign dq_next  = {dq_in[W-2:0], q_bit};

        always_ff @(posedge clk)
        begin
            dq_reg[i] <= dq_next;
        end

        if (i < W - 1)
        begin : g_carry
            logic [W-1:0] rem_next;

            // Keep the difference when the divisor fitted, else the shifted remainder
            assign rem_next = q_bit ? diff[W-1:0] : trial[W-1:0];

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                dvs_reg[i] <= dvs_in;
            end
        end
    end

    assign quotient = dq_reg[W-1];

endmodule

// ===== design/signed_int64_four_op_alu.sv =====
// Signed ALU: add, subtract, multiply (low bits) and truncating divide.
// Throughput: one request every cycle; busy stays low, the pipeline never stalls.
// Depth is set by the divider, which resolves one quotient bit per stage.
// Reset clears only the valid bits; no done is raised until new requests enter.
module signed_int64_four_op_alu
    import si64alu_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [CMD_W-1:0]       command,
    input  logic signed [XLEN-1:0] operand_a,
    input  logic signed [XLEN-1:0] operand_b,
    output logic                   done,
    output logic signed [XLEN-1:0] result_value,
    output logic                   status
);

    localparam int W      = DATA_WIDTH;
    localparam int SIDE_N = W - 1;

    typedef struct packed {
        logic         is_div;
        logic         div_zero;
        logic         q_neg;
        logic [W-1:0] value;
    } side_t;

    logic             accept;

    logic             s1_vld_reg;
    logic [CMD_W-1:0] s1_cmd_reg;
    logic [W-1:0]     s1_a_reg;
    logic [W-1:0]     s1_b_reg;

    logic             s2_vld_reg;
    logic [CMD_W-1:0] s2_cmd_reg;
    logic [W-1:0]     s2_addsub_reg;
    logic [W-1:0]     s2_addsub_next;
    logic             s2_div_zero_reg;
    logic             s2_q_neg_reg;
    logic [W-1:0]     s2_mag_a_reg;
    logic [W-1:0]     s2_mag_a_next;
    logic [W-1:0]     s2_mag_b_reg;
    logic [W-1:0]     s2_mag_b_next;

    logic             s3_vld_reg;
    logic [CMD_W-1:0] s3_cmd_reg;
    logic [W-1:0]     s3_addsub_reg;
    logic             s3_div_zero_reg;
    logic             s3_q_neg_reg;

    logic [W-1:0]     mul_prod;
    logic [W-1:0]     div_quot;

    side_t            side_next;
    side_t            side_reg [SIDE_N];
    logic             vld_reg  [SIDE_N];

    side_t            side_last;
    logic [W-1:0]     final_value;
    logic             done_reg;
    logic [XLEN-1:0]  result_reg;
    logic [XLEN-1:0]  result_next;
    logic             status_reg;
    logic             status_next;

    // Never stall the requester
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Stage 1: capture the request, keep only the low DATA_WIDTH operand bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= command;
        s1_a_reg   <= operand_a[W-1:0];
        s1_b_reg   <= operand_b[W-1:0];
    end

    // Stage 2: add or subtract, divider magnitudes and sign, zero divisor
    assign s2_addsub_next = (s1_cmd_reg == CMD_SUB) ? s1_a_reg - s1_b_reg
                                                    : s1_a_reg + s1_b_reg;
    assign s2_mag_a_next  = s1_a_reg[W-1] ? W'(0) - s1_a_reg : s1_a_reg;
    assign s2_mag_b_next  = s1_b_reg[W-1] ? W'(0) - s1_b_reg : s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg      <= s1_cmd_reg;
        s2_addsub_reg   <= s2_addsub_next;
        s2_div_zero_reg <= (s1_b_reg == '0);
        s2_q_neg_reg    <= s1_a_reg[W-1] ^ s1_b_reg[W-1];
        s2_mag_a_reg    <= s2_mag_a_next;
        s2_mag_b_reg    <= s2_mag_b_next;
    end

    // Stage 3: hold the side data while the product settles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_cmd_reg      <= s2_cmd_reg;
        s3_addsub_reg   <= s2_addsub_reg;
        s3_div_zero_reg <= s2_div_zero_reg;
        s3_q_neg_reg    <= s2_q_neg_reg;
    end

    // Product: two stages from stage 1, ready alongside stage 3
    si64alu_mul #(
        .W    (W)
    ) u_mul (
        .clk  (clk),
        .a    (s1_a_reg),
        .b    (s1_b_reg),
        .prod (mul_prod)
    );

    // Quotient magnitude: W stages from stage 2
    si64alu_div #(
        .W        (W)
    ) u_div (
        .clk      (clk),
        .dividend (s2_mag_a_reg),
        .divisor  (s2_mag_b_reg),
        .quotient (div_quot)
    );

    // Pick the non-divide result and advance it alongside the divider
    always_comb
    begin
        side_next.is_div   = (s3_cmd_reg == CMD_DIV);
        side_next.div_zero = s3_div_zero_reg;
        side_next.q_neg    = s3_q_neg_reg;
        side_next.value    = (s3_cmd_reg == CMD_MUL) ? mul_prod : s3_addsub_reg;
    end

    for (genvar k = 0; k < SIDE_N; k++)
    begin : g_side
        if (k == 0)
        begin : g_head
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else
                    vld_reg[k] <= s3_vld_reg;
            end

            always_ff @(posedge clk)
            begin
                side_reg[k] <= side_next;
            end
        end
        else
        begin : g_tail
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else
                    vld_reg[k] <= vld_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Final stage: apply the quotient sign, drop to zero on a zero divisor
    assign side_last = side_reg[SIDE_N-1];

    always_comb
    begin
        if (!side_last.is_div)
            final_value = side_last.value;
        else if (side_last.div_zero)
            final_value = '0;
        else if (side_last.q_neg)
            final_value = W'(0) - div_quot;
        else
            final_value = div_quot;
        result_next = XLEN'(signed'(final_value));
        status_next = (side_last.is_div & side_last.div_zero) ? STATUS_DIV_ZERO
                                                              : STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[SIDE_N-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

endmodule

// ===== verif/tb_signed_int64_four_op_alu.sv =====
// Self-checking testbench for the signed four-operation ALU: a directed table of
// extremes and divide corner cases, then randomised requests with random gaps.
// Depends on si64alu_pkg and signed_int64_four_op_alu from the design folder.
`timescale 1ns / 100ps

module tb_signed_int64_four_op_alu;
    import si64alu_pkg::*;

    localparam int DW           = 64;
    localparam int DRAIN_CYCLES = DW + 3 + 16;
    localparam int RANDOM_ITEMS = 650;
    localparam int PAUSE_AT     = 300;

    localparam logic [XLEN-1:0] S_MIN  = {1'b1, {(XLEN-1){1'b0}}};
    localparam logic [XLEN-1:0] S_MAX  = {1'b0, {(XLEN-1){1'b1}}};
    localparam logic [XLEN-1:0] ONES   = {XLEN{1'b1}};
    localparam logic [XLEN-1:0] W_MASK = {XLEN{1'b1}} >> (XLEN - DW);
    localparam logic [XLEN-1:0] W_SIGN = {{(XLEN-1){1'b0}}, 1'b1} << (DW - 1);

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            status;
    } alu_result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [XLEN-1:0]  a;
        logic [XLEN-1:0]  b;
        bit               typed;
        alu_result_t      res;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_W-1:0]       command;
    logic signed [XLEN-1:0] operand_a;
    logic signed [XLEN-1:0] operand_b;
    logic                   done;
    logic signed [XLEN-1:0] result_value;
    logic                   status;

    alu_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    int          error_count;
    int          checked_count;
    int          issued_per_cmd[4];
    int          div_zero_seen;

    signed_int64_four_op_alu #(
        .DATA_WIDTH (DW)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .done         (done),
        .result_value (result_value),
        .status       (status)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sign-extend from the datapath width to the port width
    function automatic logic [XLEN-1:0] sext_width(input logic [XLEN-1:0] v);
        logic [XLEN-1:0] m;
        m = v & W_MASK;
        return (m ^ W_SIGN) - W_SIGN;
    endfunction

    // Work out the value and status that one request produces
    function automatic alu_result_t alu_predict(input logic [CMD_W-1:0] cmd,
                                                input logic [XLEN-1:0] a_in,
                                                input logic [XLEN-1:0] b_in);
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] r;
        logic [XLEN-1:0] ma;
        logic [XLEN-1:0] mb;
        logic            na;
        logic            nb;
        alu_result_t     res;
        a = sext_width(a_in);
        b = sext_width(b_in);
        res.status = STATUS_OK;
        case (cmd)
            CMD_ADD: r = a + b;
            CMD_SUB: r = a - b;
            CMD_MUL: r = a * b;
            CMD_DIV:
            begin
                if ((b & W_MASK) == '0)
                begin
                    r = '0;
                    res.status = STATUS_DIV_ZERO;
                end
                else
                begin
                    // Divide magnitudes, then restore the sign (truncates toward zero)
                    na = (a & W_SIGN) != '0;
                    nb = (b & W_SIGN) != '0;
                    ma = (na ? (XLEN'(0) - a) : a) & W_MASK;
                    mb = (nb ? (XLEN'(0) - b) : b) & W_MASK;
                    r = ma / mb;
                    if (na != nb)
                        r = XLEN'(0) - r;
                end
            end
            default: r = '0;
        endcase
        res.value = sext_width(r);
        return res;
    endfunction

    // Draw an operand: full-range most often, with extremes and spread magnitudes mixed in
    function automatic logic [XLEN-1:0] rand_operand();
        logic [XLEN-1:0] v;
        int unsigned     pick;
        pick = $urandom_range(0, 11);
        v = {$urandom, $urandom};
        case (pick)
            0: v = S_MIN;
            1: v = S_MAX;
            2: v = ($urandom_range(0, 1) == 0) ? ONES : XLEN'(1);
            3: v = '0;
            4, 5, 6:
            begin
                v = v >> $urandom_range(0, XLEN - 1);
                if ($urandom_range(0, 1) == 1)
                    v = XLEN'(0) - v;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd,
                                    input logic [XLEN-1:0] a,
                                    input logic [XLEN-1:0] b,
                                    input bit typed,
                                    input logic [XLEN-1:0] value,
                                    input logic st);
        stim_row_t row;
        row.cmd = cmd;
        row.a = a;
        row.b = b;
        row.typed = typed;
        row.res.value = value;
        row.res.status = st;
        directed_rows.push_back(row);
    endfunction

    // Present one request and hold it until accepted, then log its expected result
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [XLEN-1:0] a,
                                input logic [XLEN-1:0] b,
                                input bit typed,
                                input alu_result_t typed_res);
        alu_result_t exp_res;
        @(negedge clk);
        start <= 1'b1;
        command <= cmd;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        exp_res = typed ? typed_res : alu_predict(cmd, a, b);
        pending_results.push_back(exp_res);
        issued_per_cmd[cmd]++;
        if (cmd == CMD_DIV && exp_res.status == STATUS_DIV_ZERO)
            div_zero_seen++;
    endtask

    // Drop start for the given number of cycles
    task automatic idle_for(input int unsigned cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        alu_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: result_value %0d, status %0b",
                       result_value, status);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                checked_count++;
                if (result_value !== exp_res.value)
                begin
                    $error("result_value mismatch: expected %0d, actual %0d",
                           $signed(exp_res.value), result_value);
                    error_count++;
                end
                if (status !== exp_res.status)
                begin
                    $error("status mismatch: expected %0b, actual %0b",
                           exp_res.status, status);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random requests, drain
    initial
    begin
        alu_result_t     no_res;
        logic [CMD_W-1:0] cmd;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        bit              burst;
        int              leftover;

        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_ADD;
        operand_a = '0;
        operand_b = '0;
        error_count = 0;
        checked_count = 0;
        div_zero_seen = 0;
        burst = 1'b0;
        no_res = '0;
        foreach (issued_per_cmd[i])
            issued_per_cmd[i] = 0;

        // Directed table; typed expectations only where obvious
        add_row(CMD_ADD, '0, '0, 1, '0, STATUS_OK);
        add_row(CMD_ADD, S_MAX, XLEN'(1), 1, S_MIN, STATUS_OK);
        add_row(CMD_ADD, S_MIN, S_MIN, 1, '0, STATUS_OK);
        add_row(CMD_ADD, ONES, ONES, 0, '0, STATUS_OK);
        add_row(CMD_ADD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1, ONES,
                STATUS_OK);
        add_row(CMD_SUB, S_MIN, XLEN'(1), 1, S_MAX, STATUS_OK);
        add_row(CMD_SUB, '0, S_MIN, 1, S_MIN, STATUS_OK);
        add_row(CMD_SUB, S_MAX, S_MIN, 1, ONES, STATUS_OK);
        add_row(CMD_SUB, 64'hAAAA_AAAA_AAAA_AAAA, 64'h1234_5678_9ABC_DEF0, 0, '0, STATUS_OK);
        add_row(CMD_MUL, S_MAX, S_MAX, 1, XLEN'(1), STATUS_OK);
        add_row(CMD_MUL, S_MIN, ONES, 1, S_MIN, STATUS_OK);
        add_row(CMD_MUL, S_MIN, S_MIN, 1, '0, STATUS_OK);
        add_row(CMD_MUL, 64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF, 0, '0,
                STATUS_OK);
        add_row(CMD_MUL, ONES, 64'h5555_5555_5555_5555, 0, '0, STATUS_OK);
        add_row(CMD_DIV, XLEN'(5), '0, 1, '0, STATUS_DIV_ZERO);
        add_row(CMD_DIV, S_MIN, '0, 1, '0, STATUS_DIV_ZERO);
        add_row(CMD_DIV, '0, '0, 1, '0, STATUS_DIV_ZERO);
        add_row(CMD_DIV, S_MIN, ONES, 1, S_MIN, STATUS_OK);
        add_row(CMD_DIV, -XLEN'(7), XLEN'(2), 1, -XLEN'(3), STATUS_OK);
        add_row(CMD_DIV, XLEN'(7), -XLEN'(2), 1, -XLEN'(3), STATUS_OK);
        add_row(CMD_DIV, -XLEN'(7), -XLEN'(2), 1, XLEN'(3), STATUS_OK);
        add_row(CMD_DIV, S_MAX, S_MIN, 1, '0, STATUS_OK);
        add_row(CMD_DIV, S_MIN, S_MAX, 1, ONES, STATUS_OK);
        add_row(CMD_DIV, S_MAX, XLEN'(1), 1, S_MAX, STATUS_OK);
        add_row(CMD_DIV, 64'h7654_3210_FEDC_BA98, 64'hFFFF_FFFF_0000_1234, 0, '0,
                STATUS_OK);

        // Hold reset, then release it on a falling edge
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                         directed_rows[i].typed, directed_rows[i].res);
            idle_for($urandom_range(0, 14));
        end

        // Random requests, with bursts of back-to-back issue
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            cmd = CMD_W'($urandom_range(0, 3));
            a = rand_operand();
            b = rand_operand();
            if (cmd == CMD_DIV && $urandom_range(0, 9) == 0)
                b = '0;
            send_request(cmd, a, b, 0, no_res);
            if (n == PAUSE_AT)
            begin
                // Drop start and let the pipeline empty completely
                @(negedge clk);
                start <= 1'b0;
                wait (pending_results.size() == 0);
            end
            else
                idle_for(burst ? 0 : $urandom_range(0, 14));
        end

        @(negedge clk);
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        leftover = pending_results.size();
        if (leftover != 0)
        begin
            $error("%0d expected results never arrived", leftover);
            error_count++;
        end

        $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d requests",
                 checked_count, issued_per_cmd[CMD_ADD], issued_per_cmd[CMD_SUB],
                 issued_per_cmd[CMD_MUL], issued_per_cmd[CMD_DIV]);
        $display("Divides by zero: %0d; extremes, wraps and minimum over minus one included",
                 div_zero_seen);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Abort a run that hangs
    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule
